// File: sv/wsp_pkg.sv
// shared types and constants of the weighted sampler
package wsp_pkg;

  localparam int SUM_W = 20;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  typedef enum logic [1:0] {
    ACT_WRITE     = 2'd0,
    ACT_DRAW      = 2'd1,
    ACT_RESTART   = 2'd2,
    ACT_DRAW_POOL = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_VAL,
    S_DONE
  } state_e;

endpackage

// File: sv/weighted_sampler_with_pool_unit.sv
// weighted sampler top level: entry table, draw pool and sequential weight walk
//
//  channel  | handshake                     | payload
//  ---------+-------------------------------+------------------------------------------
//  cfg      | cfg_we_i (no wait)            | cfg_wdata_i: entry count
//  in       | in_valid_i / in_ready_o       | action, entry index/weight/value, random
//  out      | out_valid_o / out_ready_i     | picked value/index, weight sum, status
//
// one item at a time: a single adder/compare walks the weight ram one entry per cycle
// write and draw walk the entry_count entries in use (a successful draw adds a value read),
// restart walks all MAX_ENTRIES entries since it copies the whole table into the pool
// reset clears the valid bits, so every weight reads as zero; no clearing pass is needed
// a result waits in the output register while the next item is already accepted
module weighted_sampler_with_pool_unit
  import wsp_pkg::*;
#(
  parameter int MAX_ENTRIES = 16,
  parameter int WEIGHT_BITS = 16,
  parameter int VALUE_BITS  = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [4:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         action_i,
  input  logic [3:0]         entry_index_i,
  input  logic [15:0]        entry_weight_i,
  input  logic signed [31:0] entry_value_i,
  input  logic [19:0]        random_draw_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] picked_value_o,
  output logic [3:0]         picked_index_o,
  output logic [19:0]        weight_sum_used_o,
  output logic [1:0]         status_o
);

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int ACC_W = ((WEIGHT_BITS > SUM_W) ? WEIGHT_BITS : SUM_W) + 1;

  // control registers
  state_e                 state_q, state_d;
  logic [4:0]             cfg_cnt_q, cfg_cnt_d;
  logic [MAX_ENTRIES-1:0] tbl_vld_q, tbl_vld_d;
  logic [MAX_ENTRIES-1:0] pool_vld_q, pool_vld_d;
  logic                   stg_vld_q, stg_vld_d;
  logic                   found_q, found_d;
  logic                   out_vld_q, out_vld_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;

  // payload registers
  action_e                act_q, act_d;
  logic [SUM_W-1:0]       rnd_q, rnd_d;
  logic [CNT_W-1:0]       len_q, len_d;
  logic [IDX_W-1:0]       stg_idx_q, stg_idx_d;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [IDX_W-1:0]       pick_q, pick_d;
  logic signed [31:0]     res_val_q, res_val_d;
  logic [3:0]             res_idx_q, res_idx_d;
  logic [SUM_W-1:0]       res_used_q, res_used_d;
  status_e                res_stat_q, res_stat_d;
  logic signed [31:0]     out_val_q, out_val_d;
  logic [3:0]             out_idx_q, out_idx_d;
  logic [SUM_W-1:0]       out_used_q, out_used_d;
  status_e                out_stat_q, out_stat_d;

  // datapath signals
  logic                   in_xfer;
  logic                   tbl_we;
  logic                   pool_we;
  logic [CNT_W-1:0]       n_act;
  logic [WEIGHT_BITS-1:0] tbl_rdata;
  logic [WEIGHT_BITS-1:0] pool_rdata;
  logic [VALUE_BITS-1:0]  val_rdata;
  logic [WEIGHT_BITS-1:0] w_sel;
  logic [ACC_W-1:0]       acc;
  logic [SUM_W-1:0]       sum_nxt;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign tbl_we     = in_xfer && (action_e'(action_i) == ACT_WRITE) &&
                      (32'(entry_index_i) < MAX_ENTRIES);
  assign pool_we    = (state_q == S_SCAN) && stg_vld_q && (act_q == ACT_RESTART);

  // entries in use, clamped to the table size
  assign n_act = (32'(cfg_cnt_q) > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES) : CNT_W'(cfg_cnt_q);

  wsp_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(MAX_ENTRIES)) u_tbl_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (IDX_W'(entry_index_i)),
    .wdata_i (WEIGHT_BITS'(entry_weight_i)),
    .raddr_i (cnt_q[IDX_W-1:0]),
    .rdata_o (tbl_rdata)
  );

  wsp_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(MAX_ENTRIES)) u_pool_ram (
    .clk_i   (clk_i),
    .we_i    (pool_we),
    .waddr_i (stg_idx_q),
    .wdata_i (tbl_rdata),
    .raddr_i (cnt_q[IDX_W-1:0]),
    .rdata_o (pool_rdata)
  );

  wsp_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ENTRIES)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (IDX_W'(entry_index_i)),
    .wdata_i (VALUE_BITS'(entry_value_i)),
    .raddr_i (pick_q),
    .rdata_o (val_rdata)
  );

  // weight of the entry in the data stage, invalid entries read as zero
  always_comb begin
    if (act_q == ACT_DRAW_POOL) begin
      w_sel = pool_vld_q[stg_idx_q] ? pool_rdata : '0;
    end else begin
      w_sel = tbl_vld_q[stg_idx_q] ? tbl_rdata : '0;
    end
    acc     = ACC_W'(sum_q) + ACC_W'(w_sel);
    sum_nxt = (acc > ACC_W'(SUM_MAX)) ? SUM_MAX : acc[SUM_W-1:0];
  end

  always_comb begin
    state_d    = state_q;
    cfg_cnt_d  = cfg_cnt_q;
    tbl_vld_d  = tbl_vld_q;
    pool_vld_d = pool_vld_q;
    stg_vld_d  = 1'b0;
    found_d    = found_q;
    out_vld_d  = out_vld_q;
    cnt_d      = cnt_q;
    act_d      = act_q;
    rnd_d      = rnd_q;
    len_d      = len_q;
    stg_idx_d  = stg_idx_q;
    sum_d      = sum_q;
    pick_d     = pick_q;
    res_val_d  = res_val_q;
    res_idx_d  = res_idx_q;
    res_used_d = res_used_q;
    res_stat_d = res_stat_q;
    out_val_d  = out_val_q;
    out_idx_d  = out_idx_q;
    out_used_d = out_used_q;
    out_stat_d = out_stat_q;

    if (cfg_we_i) begin
      cfg_cnt_d = cfg_wdata_i;
    end
    if (out_vld_q && out_ready_i) begin
      out_vld_d = 1'b0;
    end
    if (tbl_we) begin
      tbl_vld_d[IDX_W'(entry_index_i)] = 1'b1;
    end

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          act_d   = action_e'(action_i);
          rnd_d   = random_draw_i;
          cnt_d   = '0;
          sum_d   = '0;
          found_d = 1'b0;
          pick_d  = '0;
          if (action_e'(action_i) == ACT_RESTART) begin
            len_d      = CNT_W'(MAX_ENTRIES);
            pool_vld_d = tbl_vld_q;
          end else begin
            len_d = n_act;
          end
          state_d = S_SCAN;
        end
      end

      S_SCAN: begin
        // issue stage
        if (cnt_q != len_q) begin
          stg_vld_d = 1'b1;
          stg_idx_d = cnt_q[IDX_W-1:0];
          cnt_d     = cnt_q + 1'b1;
        end
        // data stage: running sum and first crossing of the random number
        if (stg_vld_q && (CNT_W'(stg_idx_q) < n_act)) begin
          sum_d = sum_nxt;
          if (!found_q && (rnd_q < sum_nxt)) begin
            found_d = 1'b1;
            pick_d  = stg_idx_q;
          end
        end
        if ((cnt_q == len_q) && !stg_vld_q) begin
          res_val_d  = '0;
          res_idx_d  = '0;
          res_used_d = sum_q;
          res_stat_d = STAT_OK;
          state_d    = S_DONE;
          case (act_q)
            ACT_DRAW: begin
              if (rnd_q >= sum_q) begin
                res_stat_d = STAT_RANGE;
              end else begin
                res_idx_d = 4'(pick_q);
                state_d   = S_VAL;
              end
            end
            ACT_DRAW_POOL: begin
              if (sum_q == '0) begin
                res_stat_d = STAT_EMPTY;
              end else if (rnd_q >= sum_q) begin
                res_stat_d = STAT_RANGE;
              end else begin
                res_idx_d          = 4'(pick_q);
                pool_vld_d[pick_q] = 1'b0;
                state_d            = S_VAL;
              end
            end
            default: begin
              res_stat_d = STAT_OK;
            end
          endcase
        end
      end

      S_VAL: begin
        res_val_d = 32'($signed(val_rdata));
        state_d   = S_DONE;
      end

      S_DONE: begin
        if (!out_vld_q || out_ready_i) begin
          out_vld_d  = 1'b1;
          out_val_d  = res_val_q;
          out_idx_d  = res_idx_q;
          out_used_d = res_used_q;
          out_stat_d = res_stat_q;
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cfg_cnt_q  <= 5'd16;
      tbl_vld_q  <= '0;
      pool_vld_q <= '0;
      stg_vld_q  <= 1'b0;
      found_q    <= 1'b0;
      out_vld_q  <= 1'b0;
      cnt_q      <= '0;
    end else begin
      state_q    <= state_d;
      cfg_cnt_q  <= cfg_cnt_d;
      tbl_vld_q  <= tbl_vld_d;
      pool_vld_q <= pool_vld_d;
      stg_vld_q  <= stg_vld_d;
      found_q    <= found_d;
      out_vld_q  <= out_vld_d;
      cnt_q      <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    rnd_q      <= rnd_d;
    len_q      <= len_d;
    stg_idx_q  <= stg_idx_d;
    sum_q      <= sum_d;
    pick_q     <= pick_d;
    res_val_q  <= res_val_d;
    res_idx_q  <= res_idx_d;
    res_used_q <= res_used_d;
    res_stat_q <= res_stat_d;
    out_val_q  <= out_val_d;
    out_idx_q  <= out_idx_d;
    out_used_q <= out_used_d;
    out_stat_q <= out_stat_d;
  end

  assign out_valid_o       = out_vld_q;
  assign picked_value_o    = out_val_q;
  assign picked_index_o    = out_idx_q;
  assign weight_sum_used_o = out_used_q;
  assign status_o          = out_stat_q;

endmodule

// File: sv/wsp_ram.sv
// generic single-write, single-read ram with registered read data
module wsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
